// ===== rtl/core/sound_voice_slot_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// sound_voice_slot_allocator_defines.svh
// Assertion macros shared by the voice slot allocator checkers.
// ----------------------------------------------------------------------------
`ifndef SOUND_VOICE_SLOT_ALLOCATOR_DEFINES_SVH
`define SOUND_VOICE_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SVSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SVSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/svsa_pkg.sv =====
// ----------------------------------------------------------------------------
// svsa_pkg
// Shared constants and chain types of the voice slot allocator.
// ----------------------------------------------------------------------------
package svsa_pkg;

  // Fixed field widths.
  localparam int MASK_BITS = 20;
  localparam int OUT_BITS  = 5;

  // Operation codes.
  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Search status rippling up the row of cells.
  typedef struct packed {
    logic found1;  // first pass already has a winner below
    logic busy1;   // first pass winner was busy (steal)
    logic found2;  // second pass already has a winner below
    logic busy2;   // second pass winner was busy (steal)
  } chain_t;

  // Update command broadcast back down to every cell.
  typedef struct packed {
    logic release_all;
    logic take1;
    logic take2;
    logic shift;
  } cmd_t;

endpackage

// ===== rtl/core/sound_voice_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// sound_voice_slot_allocator
// Voice slot allocator: a row of slot cells searched by a ripple chain.
// ----------------------------------------------------------------------------
// Channel   Handshake          Fields
// command   start / busy       operation, handle, playing_mask
// result    done (1 cycle)     slot, evicted_valid, evicted_handle, shifted,
//                              released_count
//
// An item is handled in two steps: first the command is registered, then
// the search chain through the slot cells settles and the cells commit.
// done pulses in the cycle after commit; busy is low again in that cycle,
// so a new item may be accepted while the result is shown.
// rst (synchronous) empties every slot and clears the scan pointer.
// The receiver cannot stall: a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sound_voice_slot_allocator
  import svsa_pkg::*;
#(
  parameter int SLOT_COUNT  = 20,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   operation,
  input  logic [HANDLE_BITS-1:0] handle,
  input  logic [MASK_BITS-1:0]   playing_mask,
  output logic                   done,
  output logic [OUT_BITS-1:0]    slot,
  output logic                   evicted_valid,
  output logic [HANDLE_BITS-1:0] evicted_handle,
  output logic                   shifted,
  output logic [OUT_BITS-1:0]    released_count
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int SW = $clog2(SLOT_COUNT + 1);

  // Registered command.
  logic                   op_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [MASK_BITS-1:0]   mask_r;

  // Allocator state beyond the cells.
  logic [SW-1:0] scan_start;
  logic [SW-1:0] busy_count;   // number of busy slots, tracked incrementally

  // Chain wiring: element i feeds cell i, element SLOT_COUNT is the top end.
  chain_t                 ch      [SLOT_COUNT+1];
  logic [HANDLE_BITS-1:0] ch_h1   [SLOT_COUNT+1];
  logic [HANDLE_BITS-1:0] ch_h2   [SLOT_COUNT+1];
  logic [IW-1:0]          ch_i1   [SLOT_COUNT+1];
  logic [IW-1:0]          ch_i2   [SLOT_COUNT+1];
  logic [HANDLE_BITS-1:0] cell_h  [SLOT_COUNT];
  logic                   cell_b  [SLOT_COUNT];
  logic                   play    [SLOT_COUNT];

  cmd_t   cmd;
  chain_t fin;
  logic   store_go;
  logic   fill_empty;

  assign ch[0]    = '0;
  assign ch_h1[0] = '0;
  assign ch_h2[0] = '0;
  assign ch_i1[0] = '0;
  assign ch_i2[0] = '0;
  assign fin      = ch[SLOT_COUNT];

  // Decision from the top end of the chain: first pass wins, then the
  // wrap-around pass, else every slot is playing and the pool shifts.
  assign store_go        = busy && (op_r == OP_STORE);
  assign cmd.release_all = busy && (op_r == OP_RELEASE);
  assign cmd.take1       = store_go && fin.found1;
  assign cmd.take2       = store_go && !fin.found1 && fin.found2;
  assign cmd.shift       = store_go && !fin.found1 && !fin.found2;
  assign fill_empty      = (cmd.take1 && !fin.busy1) || (cmd.take2 && !fin.busy2);

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    logic [HANDLE_BITS-1:0] up_h;
    logic                   up_b;

    // Slots past the mask width never count as playing.
    if (i < MASK_BITS) begin : g_play
      assign play[i] = mask_r[i];
    end else begin : g_noplay
      assign play[i] = 1'b0;
    end

    // On a shift the top slot takes the new handle.
    if (i == SLOT_COUNT - 1) begin : g_top
      assign up_h = handle_r;
      assign up_b = 1'b1;
    end else begin : g_mid
      assign up_h = cell_h[i+1];
      assign up_b = cell_b[i+1];
    end

    svsa_cell #(
      .INDEX       (i),
      .SLOT_COUNT  (SLOT_COUNT),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .scan_start   (scan_start),
      .playing      (play[i]),
      .cmd          (cmd),
      .new_handle   (handle_r),
      .up_handle    (up_h),
      .up_busy      (up_b),
      .cin          (ch[i]),
      .cin_handle1  (ch_h1[i]),
      .cin_handle2  (ch_h2[i]),
      .cin_idx1     (ch_i1[i]),
      .cin_idx2     (ch_i2[i]),
      .cout         (ch[i+1]),
      .cout_handle1 (ch_h1[i+1]),
      .cout_handle2 (ch_h2[i+1]),
      .cout_idx1    (ch_i1[i+1]),
      .cout_idx2    (ch_i2[i+1]),
      .handle_q     (cell_h[i]),
      .busy_q       (cell_b[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      scan_start <= '0;
      busy_count <= '0;
    end else if (busy) begin
      // Commit cycle: cells update on this edge alongside these registers.
      busy <= 1'b0;
      done <= 1'b1;
      if (op_r == OP_RELEASE) begin
        slot           <= '0;
        evicted_valid  <= 1'b0;
        evicted_handle <= '0;
        shifted        <= 1'b0;
        released_count <= OUT_BITS'(busy_count);
        busy_count     <= '0;
        scan_start     <= '0;
      end else begin
        released_count <= '0;
        shifted        <= cmd.shift;
        if (fill_empty) begin
          busy_count <= busy_count + SW'(1);
        end
        if (cmd.take1) begin
          slot           <= OUT_BITS'(ch_i1[SLOT_COUNT]);
          evicted_valid  <= fin.busy1;
          evicted_handle <= fin.busy1 ? ch_h1[SLOT_COUNT] : '0;
          // Stealing moves the pointer past the slot; an empty slot keeps it.
          scan_start     <= fin.busy1 ? SW'(ch_i1[SLOT_COUNT]) + SW'(1)
                                      : SW'(ch_i1[SLOT_COUNT]);
        end else if (cmd.take2) begin
          slot           <= OUT_BITS'(ch_i2[SLOT_COUNT]);
          evicted_valid  <= fin.busy2;
          evicted_handle <= fin.busy2 ? ch_h2[SLOT_COUNT] : '0;
          scan_start     <= SW'(ch_i2[SLOT_COUNT]) + SW'(1);
        end else begin
          // All playing: slot 0 goes, the rest move down one.
          slot           <= OUT_BITS'(SLOT_COUNT - 1);
          evicted_valid  <= 1'b1;
          evicted_handle <= cell_h[0];
          scan_start     <= SW'(SLOT_COUNT);
        end
      end
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        op_r     <= operation;
        handle_r <= handle;
        mask_r   <= playing_mask;
      end
    end
  end

endmodule

// ===== rtl/core/svsa_cell.sv =====
// ----------------------------------------------------------------------------
// svsa_cell
// One voice slot: holds handle and busy bit, joins the search chain.
// ----------------------------------------------------------------------------
module svsa_cell
  import svsa_pkg::*;
#(
  parameter int INDEX       = 0,
  parameter int SLOT_COUNT  = 20,
  parameter int HANDLE_BITS = 16,
  localparam int IW = $clog2(SLOT_COUNT),
  localparam int SW = $clog2(SLOT_COUNT + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SW-1:0]          scan_start,
  input  logic                   playing,
  input  cmd_t                   cmd,
  input  logic [HANDLE_BITS-1:0] new_handle,
  input  logic [HANDLE_BITS-1:0] up_handle,
  input  logic                   up_busy,
  input  chain_t                 cin,
  input  logic [HANDLE_BITS-1:0] cin_handle1,
  input  logic [HANDLE_BITS-1:0] cin_handle2,
  input  logic [IW-1:0]          cin_idx1,
  input  logic [IW-1:0]          cin_idx2,
  output chain_t                 cout,
  output logic [HANDLE_BITS-1:0] cout_handle1,
  output logic [HANDLE_BITS-1:0] cout_handle2,
  output logic [IW-1:0]          cout_idx1,
  output logic [IW-1:0]          cout_idx2,
  output logic [HANDLE_BITS-1:0] handle_q,
  output logic                   busy_q
);

  logic cand;
  logic hit1;
  logic hit2;

  // Usable: empty, or busy but no longer playing.
  assign cand = !(busy_q && playing);
  assign hit1 = cand && (scan_start <= SW'(INDEX)) && !cin.found1;
  assign hit2 = cand && !cin.found2;

  always_comb begin
    cout.found1  = cin.found1 | hit1;
    cout.busy1   = hit1 ? busy_q : cin.busy1;
    cout.found2  = cin.found2 | hit2;
    cout.busy2   = hit2 ? busy_q : cin.busy2;
    cout_handle1 = hit1 ? handle_q : cin_handle1;
    cout_handle2 = hit2 ? handle_q : cin_handle2;
    cout_idx1    = hit1 ? IW'(INDEX) : cin_idx1;
    cout_idx2    = hit2 ? IW'(INDEX) : cin_idx2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
    end else if (cmd.release_all) begin
      busy_q <= 1'b0;
    end else if ((cmd.take1 && hit1) || (cmd.take2 && hit2)) begin
      busy_q   <= 1'b1;
      handle_q <= new_handle;
    end else if (cmd.shift) begin
      busy_q   <= up_busy;
      handle_q <= up_handle;
    end
  end

endmodule

// ===== rtl/core/svsa_checker.sv =====
// ----------------------------------------------------------------------------
// svsa_checker
// Port-level checks of the voice slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "sound_voice_slot_allocator_defines.svh"

module svsa_checker
  import svsa_pkg::*;
#(
  parameter int SLOT_COUNT  = 20,
  parameter int HANDLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [OUT_BITS-1:0]    slot,
  input logic                   evicted_valid,
  input logic [HANDLE_BITS-1:0] evicted_handle,
  input logic                   shifted,
  input logic [OUT_BITS-1:0]    released_count
);

  `SVSA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not go busy")
  `SVSA_ASSERT_NXT(a_busy_done, busy, done && !busy, "no result one cycle after busy")
  `SVSA_ASSERT_IMP(a_shift_last, done && shifted,
    evicted_valid && (slot == OUT_BITS'(SLOT_COUNT - 1)), "shift without last-slot eviction")
  `SVSA_ASSERT_IMP(a_no_evict_zero, done && !evicted_valid, evicted_handle == '0,
    "evicted handle nonzero without eviction")
  `SVSA_ASSERT_IMP(a_release_quiet, done && (released_count != '0),
    (slot == '0) && !evicted_valid && !shifted, "release result carries store fields")

endmodule

bind sound_voice_slot_allocator svsa_checker #(
  .SLOT_COUNT  (SLOT_COUNT),
  .HANDLE_BITS (HANDLE_BITS)
) u_svsa_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sound_voice_slot_allocator: directed fill, shift,
// pointer-wrap and release cases, then random traffic, paced and at full
// rate, checked against a cycle-free model of the slot pool.
// ----------------------------------------------------------------------------
module testbench;
  import svsa_pkg::*;

  localparam int SLOT_COUNT   = 20;
  localparam int HANDLE_BITS  = 16;
  localparam int CLK_PERIOD   = 20;
  localparam int STALL_LIMIT  = 500;  // cycles with no item and no result
  localparam int DRAIN_CYCLES = 8;    // margin after the last result
  localparam int MAX_GAP      = 12;

  // One result item as the block reports it.
  typedef struct packed {
    logic [OUT_BITS-1:0]    slot;
    logic                   evicted_valid;
    logic [HANDLE_BITS-1:0] evicted_handle;
    logic                   shifted;
    logic [OUT_BITS-1:0]    released_count;
  } alloc_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   operation;
  logic [HANDLE_BITS-1:0] handle;
  logic [MASK_BITS-1:0]   playing_mask;
  logic                   done;
  logic [OUT_BITS-1:0]    slot;
  logic                   evicted_valid;
  logic [HANDLE_BITS-1:0] evicted_handle;
  logic                   shifted;
  logic [OUT_BITS-1:0]    released_count;

  sound_voice_slot_allocator #(
    .SLOT_COUNT (SLOT_COUNT),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .handle        (handle),
    .playing_mask  (playing_mask),
    .done          (done),
    .slot          (slot),
    .evicted_valid (evicted_valid),
    .evicted_handle(evicted_handle),
    .shifted       (shifted),
    .released_count(released_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the slot pool.
  logic [HANDLE_BITS-1:0] pool_handle [SLOT_COUNT];
  bit                     pool_busy   [SLOT_COUNT];
  int unsigned            scan_ptr;  // 0..SLOT_COUNT

  alloc_result_t pending_allocs[$];  // predicted results, oldest first

  int error_count;
  int store_count;
  int release_count;
  int shift_count;
  int evict_count;
  int idle_cycles;

  // Sender pacing: bursts of items separated by random gaps.
  bit pace_gaps;
  int burst_left;

  // --------------------------------------------------------------------------
  // Pool model. Applies one item to the shadow pool and returns its result.
  // --------------------------------------------------------------------------
  function automatic alloc_result_t allocate_voice(input logic op,
                                                   input logic [HANDLE_BITS-1:0] h,
                                                   input logic [MASK_BITS-1:0] mask);
    alloc_result_t r;
    bit            found;
    int            pick;
    int            i;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    if (op == OP_RELEASE) begin
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (pool_busy[i]) r.released_count = r.released_count + 1'b1;
        pool_busy[i]   = 1'b0;
        pool_handle[i] = '0;
      end
      scan_ptr = 0;
    end else begin
      // first pass: from the pointer up; playing slots push the pointer on
      for (i = scan_ptr; i < SLOT_COUNT && !found; i++) begin
        if (!pool_busy[i]) begin
          pick  = i;
          found = 1'b1;
        end else if (!(i < MASK_BITS && mask[i])) begin
          r.evicted_valid  = 1'b1;
          r.evicted_handle = pool_handle[i];
          scan_ptr         = i + 1;
          pick             = i;
          found            = 1'b1;
        end else begin
          scan_ptr = i + 1;
        end
      end
      // second pass: from slot 0, first slot that is free or idle
      for (i = 0; i < SLOT_COUNT && !found; i++) begin
        if (!(pool_busy[i] && i < MASK_BITS && mask[i])) begin
          if (pool_busy[i]) begin
            r.evicted_valid  = 1'b1;
            r.evicted_handle = pool_handle[i];
          end
          scan_ptr = i + 1;
          pick     = i;
          found    = 1'b1;
        end
      end
      // everything playing: drop slot 0 and shift the pool down
      if (!found) begin
        r.evicted_valid  = 1'b1;
        r.evicted_handle = pool_handle[0];
        r.shifted        = 1'b1;
        for (i = 0; i + 1 < SLOT_COUNT; i++) begin
          pool_handle[i] = pool_handle[i + 1];
          pool_busy[i]   = pool_busy[i + 1];
        end
        pick = SLOT_COUNT - 1;
      end
      pool_handle[pick] = h;
      pool_busy[pick]   = 1'b1;
      r.slot            = pick[OUT_BITS-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sends one item, honoring the burst/gap pacing; returns once accepted.
  // start is left high so back-to-back items need no extra edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [HANDLE_BITS-1:0] h,
                           input logic [MASK_BITS-1:0] mask);
    alloc_result_t want;
    int            gap;
    gap = 0;
    if (pace_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap        = $urandom_range(1, MAX_GAP);
      end
      burst_left--;
    end
    @(negedge clk);
    if (gap > 0) begin
      // idle: fields carry junk that must be ignored
      start        <= 1'b0;
      operation    <= 1'($urandom);
      handle       <= HANDLE_BITS'($urandom);
      playing_mask <= MASK_BITS'($urandom);
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    handle       <= h;
    playing_mask <= mask;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = allocate_voice(op, h, mask);
    pending_allocs.push_back(want);
    if (op == OP_RELEASE) release_count++;
    else store_count++;
    if (want.shifted) shift_count++;
    if (want.evicted_valid) evict_count++;
  endtask

  // Playing masks weighted toward dense, so the pool fills and the
  // all-playing shift is reached often.
  function automatic logic [MASK_BITS-1:0] pick_mask();
    logic [MASK_BITS-1:0] m;
    case ($urandom_range(0, 9))
      0, 1: m = '1;
      2, 3: begin
        m = '1;
        m[$urandom_range(0, MASK_BITS - 1)] = 1'b0;
      end
      4, 5: m = MASK_BITS'($urandom | $urandom | $urandom);
      6, 7: m = MASK_BITS'($urandom);
      8:    m = MASK_BITS'($urandom & $urandom);
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return HANDLE_BITS'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fill an empty pool with every slot playing, so each store lands in the
  // next empty slot; then an all-playing store forces the shift with eviction
  // of slot 0. Handle extremes go into the first two slots.
  task automatic test_fill_and_shift();
    int i;
    send_item(OP_STORE, '0, '1);
    send_item(OP_STORE, '1, '1);
    for (i = 2; i < SLOT_COUNT; i++) send_item(OP_STORE, HANDLE_BITS'(16'h1000 + i), '1);
    send_item(OP_STORE, 16'hA5A5, '1);  // pool full and playing: shift
  endtask

  // Pointer sits at the end of the pool after the shift: the first pass is
  // empty and the second pass steals the one idle slot. Then a pointer in
  // mid-pool steals the next idle busy slot.
  task automatic test_pointer_wrap();
    logic [MASK_BITS-1:0] m;
    m    = '1;
    m[7] = 1'b0;
    send_item(OP_STORE, 16'h5A5A, m);
    send_item(OP_STORE, 16'h0F0F, '0);
  endtask

  // Release-all on a full and on an empty pool, then a zero handle into an
  // empty pool, which still marks its slot busy and can be stolen later.
  task automatic test_release_and_zero_handle();
    send_item(OP_RELEASE, '1, '1);
    send_item(OP_RELEASE, '0, '0);
    send_item(OP_STORE, '0, '0);
    send_item(OP_STORE, 16'h00FF, '1);
    send_item(OP_STORE, 16'hFF00, '0);
  endtask

  // Random traffic: runs of stores between occasional release-all.
  task automatic test_random_traffic(input int count, input int release_pct);
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < release_pct)
        send_item(OP_RELEASE, pick_handle(), MASK_BITS'($urandom));
      else
        send_item(OP_STORE, pick_handle(), pick_mask());
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every done cycle must match the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      if (pending_allocs.size() == 0) begin
        $error("result with no item outstanding: slot %0d", slot);
        error_count++;
      end else begin
        want = pending_allocs.pop_front();
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          error_count++;
        end
        if (evicted_valid !== want.evicted_valid) begin
          $error("evicted_valid: expected %0d, got %0d", want.evicted_valid, evicted_valid);
          error_count++;
        end
        if (evicted_handle !== want.evicted_handle) begin
          $error("evicted_handle: expected %h, got %h", want.evicted_handle, evicted_handle);
          error_count++;
        end
        if (shifted !== want.shifted) begin
          $error("shifted: expected %0d, got %0d", want.shifted, shifted);
          error_count++;
        end
        if (released_count !== want.released_count) begin
          $error("released_count: expected %0d, got %0d", want.released_count,
                 released_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hang shows as a long run of cycles with no item taken and
  // no result shown.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int i;
    rst           = 1'b1;
    start         = 1'b0;
    operation     = OP_STORE;
    handle        = '0;
    playing_mask  = '0;
    error_count   = 0;
    store_count   = 0;
    release_count = 0;
    shift_count   = 0;
    evict_count   = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    pace_gaps     = 1'b0;
    scan_ptr      = 0;
    for (i = 0; i < SLOT_COUNT; i++) begin
      pool_handle[i] = '0;
      pool_busy[i]   = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed cases back to back, then with gaps
    test_fill_and_shift();
    pace_gaps = 1'b1;
    test_pointer_wrap();
    test_release_and_zero_handle();

    // random: paced dense churn, full-rate mixed traffic, paced again
    test_random_traffic(500, 2);
    pace_gaps = 1'b0;
    test_random_traffic(250, 8);
    pace_gaps = 1'b1;
    test_random_traffic(170, 5);

    @(negedge clk);
    start <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d stores and %0d release-all items", store_count,
             release_count);
    $display("with %0d evictions and %0d full-pool shifts", evict_count, shift_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
